>>> hw/rtl/ftrb_pkg.sv
// ----------------------------------------------------------------------------
// ftrb_pkg
// Shared widths, request and status codes, and the slot entry layout of the
// filtered trace ring buffer.
// ----------------------------------------------------------------------------
package ftrb_pkg;

  localparam int REQ_W       = 3;
  localparam int PID_W       = 22;
  localparam int STATE_W     = 16;
  localparam int XSTATE_W    = 6;
  localparam int NAME_W      = 64;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 32;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD    = 3'd0,
    REQ_READ      = 3'd1,
    REQ_CLEAR     = 3'd2,
    REQ_WATCH_ON  = 3'd3,
    REQ_WATCH_OFF = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_REFUSED = 2'd2
  } status_e;

  // exit states that replace the run state
  localparam logic [XSTATE_W-1:0] XST_DEAD   = 6'd16;
  localparam logic [XSTATE_W-1:0] XST_ZOMBIE = 6'd32;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [STATE_W-1:0] state;
    logic [NAME_W-1:0]  name_high;
    logic [NAME_W-1:0]  name_low;
  } slot_entry_t;

endpackage

>>> hw/rtl/ftrb_in_if.sv
// ----------------------------------------------------------------------------
// ftrb_in_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface ftrb_in_if import ftrb_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [PID_W-1:0]      pid;
  logic                  match_all;
  logic                  is_leader;
  logic [STATE_W-1:0]    task_state;
  logic [XSTATE_W-1:0]   exit_code_state;
  logic [NAME_W-1:0]     name_low;
  logic [NAME_W-1:0]     name_high;

  modport source (
    output valid, req_type, pid, match_all, is_leader, task_state,
           exit_code_state, name_low, name_high,
    input  ready
  );

  modport sink (
    input  valid, req_type, pid, match_all, is_leader, task_state,
           exit_code_state, name_low, name_high,
    output ready
  );

endinterface

>>> hw/rtl/ftrb_out_if.sv
// ----------------------------------------------------------------------------
// ftrb_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface ftrb_out_if import ftrb_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  entry_valid;
  logic [PID_W-1:0]      entry_pid;
  logic [STATE_W-1:0]    entry_state;
  logic [NAME_W-1:0]     entry_name_low;
  logic [NAME_W-1:0]     entry_name_high;
  logic [COUNT_W-1:0]    event_count;
  logic                  last;

  modport source (
    output valid, status, entry_valid, entry_pid, entry_state, entry_name_low,
           entry_name_high, event_count, last,
    input  ready
  );

  modport sink (
    input  valid, status, entry_valid, entry_pid, entry_state, entry_name_low,
           entry_name_high, event_count, last,
    output ready
  );

endinterface

>>> hw/rtl/ftrb_ram.sv
// ----------------------------------------------------------------------------
// ftrb_ram
// Generic single-port RAM, registered read, read data held when not enabled.
// ----------------------------------------------------------------------------
module ftrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/filtered_trace_ring_buffer.sv
// ----------------------------------------------------------------------------
// filtered_trace_ring_buffer
// Ring buffer of process trace events with a pid watch filter. Slots and the
// watch table live in single-port RAMs; a sequencer walks them one entry at
// a time.
// ----------------------------------------------------------------------------
//
//  channel  | dir | items
//  ---------+-----+------------------------------------------------------
//  req_i    | in  | record / read / clear / watch on / watch off request
//  rsp_o    | out | one result per request; on read one per match, or one empty item
//
//  A request that needs no table walk goes through accept and finish only.
//  A record from a leader task while watch-all is off walks the watch table,
//  as does watch on/off for one pid. Clear walks every slot; a read walks
//  until its last slot or its MAX_RESULTS-th match, each lookup being one
//  RAM read and one compare. Output stalls hold the walk in place.
//  Reset: no clearing pass; per-slot written bits make unwritten slots read
//  as zero, watch entries count only when their used bit is set.
//  A new request is taken while the previous result still sits in rsp_o.
//
module filtered_trace_ring_buffer import ftrb_pkg::*; #(
  parameter int ENTRIES     = 32,
  parameter int WATCH_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftrb_in_if.sink     req_i,
  ftrb_out_if.source  rsp_o
);

  localparam int SAW = $clog2(ENTRIES);
  localparam int WAW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam int NW  = $clog2(MAX_RESULTS + 1);
  localparam int SW  = $bits(slot_entry_t);

  localparam logic [SAW:0]   ENT_X     = (SAW+1)'(ENTRIES);
  localparam logic [SAW-1:0] LAST_SLOT = SAW'(ENTRIES - 1);
  localparam logic [WAW-1:0] WLAST     = WAW'(WATCH_SLOTS - 1);
  localparam logic [NW-1:0]  MAX_X     = NW'(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SREAD, ST_SCHECK, ST_WREAD, ST_WCHECK, ST_FINISH
  } state_e;

  // what the finish step does and reports
  typedef enum logic [2:0] {
    ACT_NONE, ACT_REFUSE, ACT_RECORD, ACT_WATCH_ADD, ACT_WATCH_FULL,
    ACT_ALL_ON, ACT_ALL_OFF, ACT_READ_END
  } act_e;

  // sequencer
  state_e              state_q, state_d;
  act_e                act_q, act_d;

  // latched request
  logic [REQ_W-1:0]    req_q, req_d;
  logic [PID_W-1:0]    pid_q, pid_d;
  logic                all_q, all_d;
  logic [STATE_W-1:0]  rec_state_q, rec_state_d;
  logic [NAME_W-1:0]   name_low_q, name_low_d;
  logic [NAME_W-1:0]   name_high_q, name_high_d;

  // ring and filter state
  logic [SAW-1:0]         oldest_q, oldest_d;
  logic [SAW-1:0]         newest_q, newest_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [ENTRIES-1:0]     written_q, written_d;
  logic [ENTRIES-1:0]     deleted_q, deleted_d;
  logic [WATCH_SLOTS-1:0] used_q, used_d;
  logic                   watch_all_q, watch_all_d;

  // walk state
  logic [SAW-1:0]      slot_idx_q, slot_idx_d;
  logic [SAW-1:0]      slot_addr_q, slot_addr_d;
  logic [WAW-1:0]      watch_idx_q, watch_idx_d;
  logic                free_found_q, free_found_d;
  logic [WAW-1:0]      free_idx_q, free_idx_d;
  logic [NW-1:0]       rd_count_q, rd_count_d;
  logic                pend_valid_q, pend_valid_d;
  slot_entry_t         pend_q, pend_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_entry_valid_q, out_entry_valid_d;
  slot_entry_t         out_entry_q, out_entry_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  // RAM ports
  logic                slot_en, slot_we;
  logic [SAW-1:0]      slot_addr;
  slot_entry_t         slot_wdata;
  logic [SW-1:0]       slot_rdata_raw;
  slot_entry_t         slot_rdata;
  logic                watch_en, watch_we;
  logic [WAW-1:0]      watch_addr;
  logic [PID_W-1:0]    watch_rdata;

  // helpers
  logic [SAW:0]        ring_sum;
  logic [SAW-1:0]      ring_addr;
  logic [SAW-1:0]      next_slot;
  slot_entry_t         slot_eff;
  logic                slot_hit;
  logic                rd_match;
  logic                watch_hit;
  logic                free_now;
  logic                slot_last_idx;
  logic                watch_last_idx;
  logic [NW-1:0]       rd_count_inc;
  logic                out_free;

  ftrb_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (slot_en),
    .we_i    (slot_we),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata_raw)
  );

  ftrb_ram #(
    .WIDTH (PID_W),
    .DEPTH (WATCH_SLOTS)
  ) u_watch_ram (
    .clk_i   (clk_i),
    .en_i    (watch_en),
    .we_i    (watch_we),
    .addr_i  (watch_addr),
    .wdata_i (pid_q),
    .rdata_o (watch_rdata)
  );

  assign slot_rdata = slot_entry_t'(slot_rdata_raw);

  // oldest + offset, wrapped into the ring
  assign ring_sum  = {1'b0, oldest_q} + {1'b0, slot_idx_q};
  assign ring_addr = (ring_sum >= ENT_X) ? SAW'(ring_sum - ENT_X) : ring_sum[SAW-1:0];
  assign next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + SAW'(1);

  // a never-written slot reads as the all-zero reset entry
  assign slot_eff      = written_q[slot_addr_q] ? slot_rdata : '0;
  assign slot_hit      = all_q || (slot_eff.pid == pid_q);
  assign rd_match      = !deleted_q[slot_addr_q] && slot_hit;
  assign watch_hit     = used_q[watch_idx_q] && (watch_rdata == pid_q);
  assign free_now      = !used_q[watch_idx_q] && !free_found_q;
  assign slot_last_idx = (slot_idx_q == LAST_SLOT);
  assign watch_last_idx = (watch_idx_q == WLAST);
  assign rd_count_inc  = rd_count_q + NW'(1);
  assign out_free      = !out_valid_q || rsp_o.ready;

  assign slot_addr  = (state_q == ST_FINISH) ? next_slot : ring_addr;
  assign slot_wdata = '{pid: pid_q, state: rec_state_q, name_high: name_high_q,
                        name_low: name_low_q};
  assign watch_addr = (state_q == ST_FINISH) ? free_idx_q : watch_idx_q;

  always_comb begin
    state_d           = state_q;
    act_d             = act_q;
    req_d             = req_q;
    pid_d             = pid_q;
    all_d             = all_q;
    rec_state_d       = rec_state_q;
    name_low_d        = name_low_q;
    name_high_d       = name_high_q;
    oldest_d          = oldest_q;
    newest_d          = newest_q;
    count_d           = count_q;
    written_d         = written_q;
    deleted_d         = deleted_q;
    used_d            = used_q;
    watch_all_d       = watch_all_q;
    slot_idx_d        = slot_idx_q;
    slot_addr_d       = slot_addr_q;
    watch_idx_d       = watch_idx_q;
    free_found_d      = free_found_q;
    free_idx_d        = free_idx_q;
    rd_count_d        = rd_count_q;
    pend_valid_d      = pend_valid_q;
    pend_d            = pend_q;
    out_valid_d       = out_valid_q && !rsp_o.ready;
    out_status_d      = out_status_q;
    out_entry_valid_d = out_entry_valid_q;
    out_entry_d       = out_entry_q;
    out_count_d       = out_count_q;
    out_last_d        = out_last_q;
    slot_en           = 1'b0;
    slot_we           = 1'b0;
    watch_en          = 1'b0;
    watch_we          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d        = req_i.req_type;
          pid_d        = req_i.pid;
          all_d        = req_i.match_all;
          name_low_d   = req_i.name_low;
          name_high_d  = req_i.name_high;
          // zombie or dead exit state overrides the run state
          if (req_i.exit_code_state == XST_DEAD || req_i.exit_code_state == XST_ZOMBIE) begin
            rec_state_d = STATE_W'(req_i.exit_code_state);
          end else begin
            rec_state_d = req_i.task_state;
          end
          slot_idx_d   = '0;
          watch_idx_d  = '0;
          free_found_d = 1'b0;
          rd_count_d   = '0;
          pend_valid_d = 1'b0;
          case (req_i.req_type)
            REQ_RECORD: begin
              if (!req_i.is_leader) begin
                act_d   = ACT_REFUSE;
                state_d = ST_FINISH;
              end else if (watch_all_q) begin
                act_d   = ACT_RECORD;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_WREAD;
              end
            end
            REQ_READ, REQ_CLEAR: begin
              state_d = ST_SREAD;
            end
            REQ_WATCH_ON: begin
              if (req_i.match_all) begin
                act_d   = ACT_ALL_ON;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_WREAD;
              end
            end
            REQ_WATCH_OFF: begin
              if (req_i.match_all) begin
                act_d   = ACT_ALL_OFF;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_WREAD;
              end
            end
            default: begin
              act_d   = ACT_NONE;
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_SREAD: begin
        slot_en     = 1'b1;
        slot_addr_d = ring_addr;
        state_d     = ST_SCHECK;
      end

      ST_SCHECK: begin
        if (req_q == REQ_READ) begin
          // a second match pushes the held one out; wait if rsp_o is busy
          if (!(rd_match && pend_valid_q && !out_free)) begin
            if (rd_match) begin
              if (pend_valid_q) begin
                out_valid_d       = 1'b1;
                out_status_d      = STATUS_OK;
                out_entry_valid_d = 1'b1;
                out_entry_d       = pend_q;
                out_count_d       = count_q;
                out_last_d        = 1'b0;
              end
              pend_d       = slot_eff;
              pend_valid_d = 1'b1;
              rd_count_d   = rd_count_inc;
            end
            if (slot_last_idx || (rd_match && rd_count_inc == MAX_X)) begin
              act_d   = ACT_READ_END;
              state_d = ST_FINISH;
            end else begin
              slot_idx_d = slot_idx_q + SAW'(1);
              state_d    = ST_SREAD;
            end
          end
        end else begin
          if (slot_hit) begin
            deleted_d[slot_addr_q] = 1'b1;
          end
          if (slot_last_idx) begin
            act_d   = ACT_NONE;
            state_d = ST_FINISH;
          end else begin
            slot_idx_d = slot_idx_q + SAW'(1);
            state_d    = ST_SREAD;
          end
        end
      end

      ST_WREAD: begin
        watch_en = 1'b1;
        state_d  = ST_WCHECK;
      end

      ST_WCHECK: begin
        case (req_q)
          REQ_RECORD: begin
            if (watch_hit) begin
              act_d   = ACT_RECORD;
              state_d = ST_FINISH;
            end else if (watch_last_idx) begin
              act_d   = ACT_REFUSE;
              state_d = ST_FINISH;
            end else begin
              watch_idx_d = watch_idx_q + WAW'(1);
              state_d     = ST_WREAD;
            end
          end
          REQ_WATCH_ON: begin
            if (watch_hit) begin
              act_d   = ACT_NONE;
              state_d = ST_FINISH;
            end else begin
              if (free_now) begin
                free_found_d = 1'b1;
                free_idx_d   = watch_idx_q;
              end
              if (watch_last_idx) begin
                act_d   = (free_found_q || free_now) ? ACT_WATCH_ADD : ACT_WATCH_FULL;
                state_d = ST_FINISH;
              end else begin
                watch_idx_d = watch_idx_q + WAW'(1);
                state_d     = ST_WREAD;
              end
            end
          end
          default: begin
            // single-pid disable
            if (watch_hit) begin
              used_d[watch_idx_q] = 1'b0;
            end
            if (watch_last_idx) begin
              act_d   = ACT_NONE;
              state_d = ST_FINISH;
            end else begin
              watch_idx_d = watch_idx_q + WAW'(1);
              state_d     = ST_WREAD;
            end
          end
        endcase
      end

      ST_FINISH: begin
        if (out_free) begin
          case (act_q)
            ACT_RECORD: begin
              slot_en              = 1'b1;
              slot_we              = 1'b1;
              written_d[next_slot] = 1'b1;
              deleted_d[next_slot] = 1'b0;
              newest_d             = next_slot;
              if (oldest_q == next_slot) begin
                oldest_d = (next_slot == LAST_SLOT) ? '0 : next_slot + SAW'(1);
              end
              count_d = count_q + COUNT_W'(1);
            end
            ACT_WATCH_ADD: begin
              watch_en           = 1'b1;
              watch_we           = 1'b1;
              used_d[free_idx_q] = 1'b1;
            end
            ACT_ALL_ON: begin
              watch_all_d = 1'b1;
            end
            ACT_ALL_OFF: begin
              watch_all_d = 1'b0;
              used_d      = '0;
            end
            default: begin
            end
          endcase

          out_valid_d = 1'b1;
          case (act_q)
            ACT_REFUSE:     out_status_d = STATUS_REFUSED;
            ACT_WATCH_FULL: out_status_d = STATUS_FULL;
            default:        out_status_d = STATUS_OK;
          endcase
          // last read result is the held match, or an empty item if none
          out_entry_valid_d = (act_q == ACT_READ_END) && pend_valid_q;
          out_entry_d       = ((act_q == ACT_READ_END) && pend_valid_q) ? pend_q : '0;
          out_count_d       = count_d;
          out_last_d        = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      act_q             <= ACT_NONE;
      req_q             <= '0;
      pid_q             <= '0;
      all_q             <= 1'b0;
      rec_state_q       <= '0;
      name_low_q        <= '0;
      name_high_q       <= '0;
      oldest_q          <= '0;
      newest_q          <= LAST_SLOT;
      count_q           <= '0;
      written_q         <= '0;
      deleted_q         <= '0;
      used_q            <= '0;
      watch_all_q       <= 1'b0;
      slot_idx_q        <= '0;
      slot_addr_q       <= '0;
      watch_idx_q       <= '0;
      free_found_q      <= 1'b0;
      free_idx_q        <= '0;
      rd_count_q        <= '0;
      pend_valid_q      <= 1'b0;
      pend_q            <= '0;
      out_valid_q       <= 1'b0;
      out_status_q      <= '0;
      out_entry_valid_q <= 1'b0;
      out_entry_q       <= '0;
      out_count_q       <= '0;
      out_last_q        <= 1'b0;
    end else begin
      state_q           <= state_d;
      act_q             <= act_d;
      req_q             <= req_d;
      pid_q             <= pid_d;
      all_q             <= all_d;
      rec_state_q       <= rec_state_d;
      name_low_q        <= name_low_d;
      name_high_q       <= name_high_d;
      oldest_q          <= oldest_d;
      newest_q          <= newest_d;
      count_q           <= count_d;
      written_q         <= written_d;
      deleted_q         <= deleted_d;
      used_q            <= used_d;
      watch_all_q       <= watch_all_d;
      slot_idx_q        <= slot_idx_d;
      slot_addr_q       <= slot_addr_d;
      watch_idx_q       <= watch_idx_d;
      free_found_q      <= free_found_d;
      free_idx_q        <= free_idx_d;
      rd_count_q        <= rd_count_d;
      pend_valid_q      <= pend_valid_d;
      pend_q            <= pend_d;
      out_valid_q       <= out_valid_d;
      out_status_q      <= out_status_d;
      out_entry_valid_q <= out_entry_valid_d;
      out_entry_q       <= out_entry_d;
      out_count_q       <= out_count_d;
      out_last_q        <= out_last_d;
    end
  end

  // ports
  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.entry_valid     = out_entry_valid_q;
  assign rsp_o.entry_pid       = out_entry_q.pid;
  assign rsp_o.entry_state     = out_entry_q.state;
  assign rsp_o.entry_name_low  = out_entry_q.name_low;
  assign rsp_o.entry_name_high = out_entry_q.name_high;
  assign rsp_o.event_count     = out_count_q;
  assign rsp_o.last            = out_last_q;

  // oldest slot always sits right after the newest one
  a_ring_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q == next_slot)
    else $error("ring pointers out of step");

  // a read never holds more matches than the result limit
  a_read_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_count_q <= MAX_X)
    else $error("read match count over limit");

  // an item carrying an entry always reports ok
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_entry_valid_q |-> out_status_q == STATUS_OK)
    else $error("entry item with non-ok status");

  // the event count moves by one, and only on a stored record
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != count_d |-> (state_q == ST_FINISH) && (act_q == ACT_RECORD)
                           && (count_d == count_q + COUNT_W'(1)))
    else $error("event count changed outside a record");

endmodule
